>>> hdl/iba_pkg.sv
package iba_pkg;

	// Disk geometry.
	localparam int DISK_BLOCKS  = 64;
	localparam int DIRECT_SLOTS = 12;
	localparam int BLOCK_BYTES  = 4096;

	// Field widths of the request and result items.
	localparam int SIZE_W = 19;
	localparam int KIND_W = 3;
	localparam int SLOT_W = 6;
	localparam int BLK_W  = 6;

	// Derived widths.
	localparam int BLK_SHIFT = $clog2(BLOCK_BYTES);
	localparam int NEED_W    = SIZE_W - BLK_SHIFT + 1;
	localparam int PTR_W     = $clog2(DISK_BLOCKS);
	localparam int CNT_W     = $clog2(DISK_BLOCKS);
	localparam int FREE_W    = $clog2(DISK_BLOCKS + 1);
	localparam int CMP_W     = ((NEED_W > FREE_W) ? NEED_W : FREE_W) + 1;

	// Result kinds.
	localparam logic [KIND_W-1:0] KIND_DIRECT   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_INDIRECT = 3'd1;
	localparam logic [KIND_W-1:0] KIND_ENTRY    = 3'd2;
	localparam logic [KIND_W-1:0] KIND_NOSPACE  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_EMPTY    = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SINGLE,
		ST_DIRECT,
		ST_MARK,
		ST_FIND,
		ST_ENTRY
	} st_t;

endpackage

>>> hdl/iba_ifs.sv
interface iba_req_if;
	logic                       valid;
	logic                       ready;
	logic [iba_pkg::SIZE_W-1:0] file_size;

	modport source (output valid, output file_size, input ready);
	modport sink   (input valid, input file_size, output ready);
endinterface

interface iba_res_if;
	logic                       valid;
	logic                       ready;
	logic [iba_pkg::KIND_W-1:0] kind;
	logic [iba_pkg::SLOT_W-1:0] slot;
	logic [iba_pkg::BLK_W-1:0]  block_number;
	logic                       last;

	modport source (output valid, output kind, output slot, output block_number,
		output last, input ready);
	modport sink   (input valid, input kind, input slot, input block_number,
		input last, output ready);
endinterface

>>> hdl/inode_block_allocator.sv
// Inode block allocator: first-fit over a free bitmap, direct slots, one indirect block.
// The item is taken, then the single scan pointer walks the bitmap one position a cycle,
// holding at a block to be reported while the sink stalls; blocks past the direct slots
// cost a second pass. A refused or empty file gets a single result and no scan.
// One item is handled at a time; the next is taken once the last result is registered.
// Reset clears the whole bitmap and the used count at once; no result is pending after it.
module inode_block_allocator (
	input  logic              clk,
	input  logic              arst_n,
	iba_req_if.sink           req,
	iba_res_if.source         res
);

	// Free bitmap and its population count. The bitmap is held in flip-flops so that
	// reset frees every block in one go.
	logic [iba_pkg::DISK_BLOCKS-1:0] used_q;
	logic [iba_pkg::FREE_W-1:0]      used_cnt_q;

	// Sequencer state. The scan pointer walks the bitmap one position a cycle unless a result
	// waits on the sink; cnt_q counts data blocks handled so far, slot_q the reported slots.
	iba_pkg::st_t               state_q, state_d;
	logic [iba_pkg::PTR_W-1:0]  ptr_q, ptr_d;
	logic [iba_pkg::PTR_W-1:0]  save_q, save_d;
	logic [iba_pkg::CNT_W-1:0]  cnt_q, cnt_d;
	logic [iba_pkg::CNT_W-1:0]  need_q, need_d;
	logic [iba_pkg::SLOT_W-1:0] slot_q, slot_d;
	logic                       ind_ok_q, ind_ok_d;
	logic [iba_pkg::KIND_W-1:0] single_kind_q, single_kind_d;

	// Output register: it holds one finished result, so the sequencer may move on
	// while the sink is still stalling.
	logic                       out_valid_q;
	logic [iba_pkg::KIND_W-1:0] out_kind_q;
	logic [iba_pkg::SLOT_W-1:0] out_slot_q;
	logic [iba_pkg::BLK_W-1:0]  out_blk_q;
	logic                       out_last_q;

	logic                       emit;
	logic [iba_pkg::KIND_W-1:0] emit_kind;
	logic [iba_pkg::SLOT_W-1:0] emit_slot;
	logic [iba_pkg::BLK_W-1:0]  emit_blk;
	logic                       emit_last;
	logic                       mark;

	logic                       out_free;
	logic                       bit_free;
	logic [iba_pkg::CNT_W-1:0]  cnt_inc;
	logic [iba_pkg::NEED_W-1:0] need_w;
	logic [iba_pkg::FREE_W-1:0] free_w;
	logic                       refuse;
	logic                       ind_ok_w;

	assign out_free = !out_valid_q || res.ready;
	assign bit_free = !used_q[ptr_q];
	assign cnt_inc  = cnt_q + 1'b1;

	// Rounding up to whole blocks is a shift plus a carry from the low bits. The refusal
	// test and the check that an indirect block will still be free afterwards are both
	// settled here, as only this item's data blocks are taken before the indirect block.
	assign need_w   = iba_pkg::NEED_W'(req.file_size >> iba_pkg::BLK_SHIFT)
		+ iba_pkg::NEED_W'(|req.file_size[iba_pkg::BLK_SHIFT-1:0]);
	assign free_w   = iba_pkg::FREE_W'(iba_pkg::DISK_BLOCKS) - used_cnt_q;
	assign refuse   = iba_pkg::CMP_W'(need_w) >= iba_pkg::CMP_W'(free_w);
	assign ind_ok_w = (iba_pkg::CMP_W'(need_w) + iba_pkg::CMP_W'(1))
		< iba_pkg::CMP_W'(free_w);

	assign req.ready = (state_q == iba_pkg::ST_IDLE);

	always_comb begin
		state_d       = state_q;
		ptr_d         = ptr_q;
		save_d        = save_q;
		cnt_d         = cnt_q;
		need_d        = need_q;
		slot_d        = slot_q;
		ind_ok_d      = ind_ok_q;
		single_kind_d = single_kind_q;
		emit          = 1'b0;
		emit_kind     = iba_pkg::KIND_DIRECT;
		emit_slot     = '0;
		emit_blk      = '0;
		emit_last     = 1'b0;
		mark          = 1'b0;

		unique case (state_q)
			iba_pkg::ST_IDLE: begin
				if (req.valid) begin
					if (refuse) begin
						single_kind_d = iba_pkg::KIND_NOSPACE;
						state_d       = iba_pkg::ST_SINGLE;
					end else if (need_w == '0) begin
						single_kind_d = iba_pkg::KIND_EMPTY;
						state_d       = iba_pkg::ST_SINGLE;
					end else begin
						// Not refused, so the count is below the disk size.
						need_d   = iba_pkg::CNT_W'(need_w);
						ind_ok_d = ind_ok_w;
						ptr_d    = '0;
						cnt_d    = '0;
						slot_d   = '0;
						state_d  = iba_pkg::ST_DIRECT;
					end
				end
			end

			iba_pkg::ST_SINGLE: begin
				if (out_free) begin
					emit      = 1'b1;
					emit_kind = single_kind_q;
					emit_last = 1'b1;
					state_d   = iba_pkg::ST_IDLE;
				end
			end

			// Data blocks for the direct slots, taken and reported as they are found.
			iba_pkg::ST_DIRECT: begin
				if (!bit_free) begin
					ptr_d = ptr_q + 1'b1;
				end else if (out_free) begin
					mark      = 1'b1;
					emit      = 1'b1;
					emit_kind = iba_pkg::KIND_DIRECT;
					emit_slot = slot_q;
					emit_blk  = iba_pkg::BLK_W'(ptr_q);
					emit_last = (cnt_inc == need_q);
					cnt_d     = cnt_inc;
					slot_d    = slot_q + 1'b1;
					ptr_d     = ptr_q + 1'b1;
					if (cnt_inc == need_q) begin
						state_d = iba_pkg::ST_IDLE;
					end else if (slot_q == iba_pkg::SLOT_W'(iba_pkg::DIRECT_SLOTS - 1)) begin
						slot_d  = '0;
						save_d  = ptr_q + 1'b1;
						state_d = ind_ok_q ? iba_pkg::ST_FIND : iba_pkg::ST_MARK;
					end
				end
			end

			// No room for the indirect block: the rest of the data blocks are still
			// taken, silently, before the no-space result goes out.
			iba_pkg::ST_MARK: begin
				ptr_d = ptr_q + 1'b1;
				if (bit_free) begin
					mark  = 1'b1;
					cnt_d = cnt_inc;
					if (cnt_inc == need_q) begin
						single_kind_d = iba_pkg::KIND_NOSPACE;
						state_d       = iba_pkg::ST_SINGLE;
					end
				end
			end

			// Skip over the free blocks the remaining data will take; the next free one
			// is the indirect block. Its number must go out before the entries.
			iba_pkg::ST_FIND: begin
				if (!bit_free) begin
					ptr_d = ptr_q + 1'b1;
				end else if (cnt_q != need_q) begin
					cnt_d = cnt_inc;
					ptr_d = ptr_q + 1'b1;
				end else if (out_free) begin
					mark      = 1'b1;
					emit      = 1'b1;
					emit_kind = iba_pkg::KIND_INDIRECT;
					emit_blk  = iba_pkg::BLK_W'(ptr_q);
					ptr_d     = save_q;
					cnt_d     = iba_pkg::CNT_W'(iba_pkg::DIRECT_SLOTS);
					state_d   = iba_pkg::ST_ENTRY;
				end
			end

			// Second pass over the skipped region, taking the data blocks as entries.
			iba_pkg::ST_ENTRY: begin
				if (!bit_free) begin
					ptr_d = ptr_q + 1'b1;
				end else if (out_free) begin
					mark      = 1'b1;
					emit      = 1'b1;
					emit_kind = iba_pkg::KIND_ENTRY;
					emit_slot = slot_q;
					emit_blk  = iba_pkg::BLK_W'(ptr_q);
					emit_last = (cnt_inc == need_q);
					cnt_d     = cnt_inc;
					slot_d    = slot_q + 1'b1;
					ptr_d     = ptr_q + 1'b1;
					if (cnt_inc == need_q) begin
						state_d = iba_pkg::ST_IDLE;
					end
				end
			end

			default: begin
				state_d = iba_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= iba_pkg::ST_IDLE;
			used_q      <= '0;
			used_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (mark) begin
				used_q[ptr_q] <= 1'b1;
				used_cnt_q    <= used_cnt_q + 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		ptr_q         <= ptr_d;
		save_q        <= save_d;
		cnt_q         <= cnt_d;
		need_q        <= need_d;
		slot_q        <= slot_d;
		ind_ok_q      <= ind_ok_d;
		single_kind_q <= single_kind_d;
		if (emit) begin
			out_kind_q <= emit_kind;
			out_slot_q <= emit_slot;
			out_blk_q  <= emit_blk;
			out_last_q <= emit_last;
		end
	end

	assign res.valid        = out_valid_q;
	assign res.kind         = out_kind_q;
	assign res.slot         = out_slot_q;
	assign res.block_number = out_blk_q;
	assign res.last         = out_last_q;

endmodule

>>> hdl/iba_checker.sv
module iba_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       req_valid,
	input logic                       req_ready,
	input logic                       res_valid,
	input logic                       res_ready,
	input logic [iba_pkg::KIND_W-1:0] res_kind,
	input logic                       res_last
);

	// A pending result is not withdrawn.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result withdrawn while stalled");

	// The allocator is not ready in the cycle after it takes an item.
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while previous one in progress");

	// Refusal and empty-file results end their request.
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_kind == iba_pkg::KIND_NOSPACE || res_kind == iba_pkg::KIND_EMPTY)
		|-> res_last)
		else $error("no-space or empty result without last");

	// The indirect block is always followed by at least one entry.
	a_indirect_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_kind == iba_pkg::KIND_INDIRECT |-> !res_last)
		else $error("indirect block result marked last");

endmodule

bind inode_block_allocator iba_checker u_iba_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_kind  (res.kind),
	.res_last  (res.last)
);
